// ===== rtl/aabbt_pkg.sv =====
// Package: word types, field widths and register codes of the box transform.
`timescale 1ns / 1ps
package aabbt_pkg;

   localparam int CoordW = 32;
   localparam int CoefW  = 20;
   localparam int FracW  = 16;
   localparam int RowW   = 3 * CoefW;
   localparam int ProdW  = CoefW + CoordW;
   localparam int TermW  = ProdW - FracW;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_XROW = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_YROW = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_ZROW = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_XOFF = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_YOFF = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_ZOFF = 3'd5;

   // identity: 1.0 on the diagonal
   localparam logic [RowW-1:0] XROW_RESET = RowW'(64'h10000);
   localparam logic [RowW-1:0] YROW_RESET = RowW'(64'h10000) << CoefW;
   localparam logic [RowW-1:0] ZROW_RESET = RowW'(64'h10000) << (2 * CoefW);

   typedef struct packed {
      logic signed [CoordW-1:0] lo_x;
      logic signed [CoordW-1:0] lo_y;
      logic signed [CoordW-1:0] lo_z;
      logic signed [CoordW-1:0] hi_x;
      logic signed [CoordW-1:0] hi_y;
      logic signed [CoordW-1:0] hi_z;
   } box_in_type;

   typedef struct packed {
      logic signed [CoordW-1:0] new_lo_x;
      logic signed [CoordW-1:0] new_lo_y;
      logic signed [CoordW-1:0] new_lo_z;
      logic signed [CoordW-1:0] new_hi_x;
      logic signed [CoordW-1:0] new_hi_y;
      logic signed [CoordW-1:0] new_hi_z;
   } box_out_type;

   // per-stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage

// ===== rtl/aabb_affine_transform.sv =====
// Top level: register file, four-stage pipeline control and three axis datapaths.
`timescale 1ns / 1ps
// Maps an axis-aligned box through a 3x3 Q4.16 matrix plus Q16.16 offset and
// returns the bounding box of the result, saturated to 32 bits. One word is taken
// per clock while req_stall is low; each word passes the product, min/max, partial
// sum and final sum with saturation stages. rsp_stall holds the
// whole pipeline only where it is full, so bubbles are squeezed out. Registers
// reset to the identity map; write them only while the pipeline is empty.
module aabb_affine_transform (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  aabbt_pkg::box_in_type             req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output aabbt_pkg::box_out_type            rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [aabbt_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [aabbt_pkg::RowW-1:0]        csr_data
);
   import aabbt_pkg::*;

   logic [RowW-1:0]   row_ff [3];
   logic [CoordW-1:0] off_ff [3];
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   adv_type adv;
   logic [2:0][CoordW-1:0] lo_in, hi_in;
   logic signed [CoordW-1:0] new_lo [3];
   logic signed [CoordW-1:0] new_hi [3];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= XROW_RESET;
         row_ff[1] <= YROW_RESET;
         row_ff[2] <= ZROW_RESET;
         off_ff[0] <= '0;
         off_ff[1] <= '0;
         off_ff[2] <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_XROW: row_ff[0] <= csr_data;
            CSR_YROW: row_ff[1] <= csr_data;
            CSR_ZROW: row_ff[2] <= csr_data;
            CSR_XOFF: off_ff[0] <= csr_data[CoordW-1:0];
            CSR_YOFF: off_ff[1] <= csr_data[CoordW-1:0];
            CSR_ZOFF: off_ff[2] <= csr_data[CoordW-1:0];
            default: ;
         endcase
      end
   end

   assign adv.s4 = !v4_ff || !rsp_stall;
   assign adv.s3 = !v3_ff || adv.s4;
   assign adv.s2 = !v2_ff || adv.s3;
   assign adv.s1 = !v1_ff || adv.s2;
   assign req_stall = !adv.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv.s1) v1_ff <= req_valid;
         if (adv.s2) v2_ff <= v1_ff;
         if (adv.s3) v3_ff <= v2_ff;
         if (adv.s4) v4_ff <= v3_ff;
      end
   end

   assign lo_in = {req_data.lo_z, req_data.lo_y, req_data.lo_x};
   assign hi_in = {req_data.hi_z, req_data.hi_y, req_data.hi_x};

   genvar r;
   generate
      for (r = 0; r < 3; r++) begin : g_axis
         aabbt_axis u_axis (
            .clock  (clock),
            .adv    (adv),
            .coef   (row_ff[r]),
            .offset (off_ff[r]),
            .lo     (lo_in),
            .hi     (hi_in),
            .new_lo (new_lo[r]),
            .new_hi (new_hi[r])
         );
      end
   endgenerate

   assign rsp_valid         = v4_ff;
   assign rsp_data.new_lo_x = new_lo[0];
   assign rsp_data.new_lo_y = new_lo[1];
   assign rsp_data.new_lo_z = new_lo[2];
   assign rsp_data.new_hi_x = new_hi[0];
   assign rsp_data.new_hi_y = new_hi[1];
   assign rsp_data.new_hi_z = new_hi[2];

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall) |-> req_stall)
      else $error("full pipeline under stall still takes a word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!v1_ff && !v2_ff && !v3_ff && !v4_ff))
      else $error("pipeline not empty after reset");

   a_hold_s2: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !adv.s3) |=> v2_ff)
      else $error("held word lost from stage two");

   a_hold_s4: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && v3_ff && rsp_stall) |=> v3_ff)
      else $error("held word lost from stage three while output is stalled");

endmodule

// ===== rtl/aabbt_axis.sv =====
// One output axis: products, per-column min/max, summation and saturation.
`timescale 1ns / 1ps
module aabbt_axis (
   input  logic                            clock,
   input  aabbt_pkg::adv_type              adv,
   input  logic [aabbt_pkg::RowW-1:0]      coef,
   input  logic [aabbt_pkg::CoordW-1:0]    offset,
   input  logic [2:0][aabbt_pkg::CoordW-1:0] lo,
   input  logic [2:0][aabbt_pkg::CoordW-1:0] hi,
   output logic signed [aabbt_pkg::CoordW-1:0] new_lo,
   output logic signed [aabbt_pkg::CoordW-1:0] new_hi
);
   import aabbt_pkg::*;

   localparam int PairW = TermW + 1;
   localparam int SumW  = TermW + 2;
   localparam logic signed [SumW-1:0] SatHi = SumW'(64'sd2147483647);
   localparam logic signed [SumW-1:0] SatLo = SumW'(-64'sd2147483648);

   logic signed [TermW-1:0] a_ff [3];
   logic signed [TermW-1:0] b_ff [3];
   logic signed [TermW-1:0] mn_ff [3];
   logic signed [TermW-1:0] mx_ff [3];
   logic signed [PairW-1:0] mn01_ff, mn2o_ff, mx01_ff, mx2o_ff;
   logic signed [CoordW-1:0] lo_ff, hi_ff;
   logic signed [PairW-1:0] off_ext;
   logic signed [SumW-1:0] mn_sum, mx_sum;

   genvar c;
   generate
      for (c = 0; c < 3; c++) begin : g_col
         logic signed [CoefW-1:0] k;
         logic signed [ProdW-1:0] p_lo, p_hi;
         assign k    = $signed(coef[c*CoefW +: CoefW]);
         assign p_lo = k * $signed(lo[c]);
         assign p_hi = k * $signed(hi[c]);

         always_ff @(posedge clock) begin
            if (adv.s1) begin
               a_ff[c] <= p_lo[ProdW-1:FracW];
               b_ff[c] <= p_hi[ProdW-1:FracW];
            end
            if (adv.s2) begin
               mn_ff[c] <= (a_ff[c] < b_ff[c]) ? a_ff[c] : b_ff[c];
               mx_ff[c] <= (a_ff[c] < b_ff[c]) ? b_ff[c] : a_ff[c];
            end
         end
      end
   endgenerate

   assign off_ext = $signed({{(PairW-CoordW){offset[CoordW-1]}}, offset});
   assign mn_sum  = $signed({mn01_ff[PairW-1], mn01_ff}) + $signed({mn2o_ff[PairW-1], mn2o_ff});
   assign mx_sum  = $signed({mx01_ff[PairW-1], mx01_ff}) + $signed({mx2o_ff[PairW-1], mx2o_ff});

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         mn01_ff <= $signed({mn_ff[0][TermW-1], mn_ff[0]}) + $signed({mn_ff[1][TermW-1], mn_ff[1]});
         mx01_ff <= $signed({mx_ff[0][TermW-1], mx_ff[0]}) + $signed({mx_ff[1][TermW-1], mx_ff[1]});
         mn2o_ff <= $signed({mn_ff[2][TermW-1], mn_ff[2]}) + off_ext;
         mx2o_ff <= $signed({mx_ff[2][TermW-1], mx_ff[2]}) + off_ext;
      end
      if (adv.s4) begin
         if (mn_sum > SatHi) begin
            lo_ff <= SatHi[CoordW-1:0];
         end else if (mn_sum < SatLo) begin
            lo_ff <= SatLo[CoordW-1:0];
         end else begin
            lo_ff <= mn_sum[CoordW-1:0];
         end
         if (mx_sum > SatHi) begin
            hi_ff <= SatHi[CoordW-1:0];
         end else if (mx_sum < SatLo) begin
            hi_ff <= SatLo[CoordW-1:0];
         end else begin
            hi_ff <= mx_sum[CoordW-1:0];
         end
      end
   end

   assign new_lo = lo_ff;
   assign new_hi = hi_ff;

endmodule

// ===== dv/aabb_affine_transform_tb.sv =====
// Testbench for aabb_affine_transform: bounding-box predictor, result checker and test tasks.
`timescale 1ns / 1ps
module aabb_affine_transform_tb;
   import aabbt_pkg::*;

   localparam int PipeDepth = 4;
   localparam logic [CsrIdxW-1:0] CSR_SPARE6 = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_SPARE7 = 3'd7;
   localparam logic [CoefW-1:0]   COEF_ONE   = 20'h10000;
   localparam logic [CoefW-1:0]   COEF_MIN   = 20'h80000;
   localparam logic [CoefW-1:0]   COEF_MAX   = 20'h7FFFF;
   localparam logic [CoordW-1:0]  COORD_MIN  = 32'h8000_0000;
   localparam logic [CoordW-1:0]  COORD_MAX  = 32'h7FFF_FFFF;
   localparam logic [CoordW-1:0]  COORD_ONE  = 32'h0001_0000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   box_in_type           req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   box_out_type          rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [RowW-1:0]      csr_data  = '0;

   logic [RowW-1:0]      map_row [3];
   logic [CoordW-1:0]    map_off [3];
   box_out_type          bounds_due [$];
   bit                   steady      = 1'b0;
   int                   hold_cycles = 0;
   int                   mismatches  = 0;

   aabb_affine_transform dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [CoordW-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return COORD_MAX;
      if (v < -64'sd2147483648) return COORD_MIN;
      return v[CoordW-1:0];
   endfunction

   // min/max of each column's two truncated products, summed with the offset
   function automatic box_out_type map_box(box_in_type box);
      logic signed [CoordW-1:0] lo [3];
      logic signed [CoordW-1:0] hi [3];
      logic [CoordW-1:0] lo_out [3];
      logic [CoordW-1:0] hi_out [3];
      longint coef, p_lo, p_hi, sum_lo, sum_hi;
      box_out_type res;
      lo[0] = box.lo_x; lo[1] = box.lo_y; lo[2] = box.lo_z;
      hi[0] = box.hi_x; hi[1] = box.hi_y; hi[2] = box.hi_z;
      for (int r = 0; r < 3; r++) begin
         sum_lo = longint'($signed(map_off[r]));
         sum_hi = sum_lo;
         for (int c = 0; c < 3; c++) begin
            coef = longint'($signed(map_row[r][c*CoefW +: CoefW]));
            p_lo = (coef * longint'(lo[c])) >>> FracW;
            p_hi = (coef * longint'(hi[c])) >>> FracW;
            if (p_lo < p_hi) begin
               sum_lo += p_lo;
               sum_hi += p_hi;
            end else begin
               sum_lo += p_hi;
               sum_hi += p_lo;
            end
         end
         lo_out[r] = clamp32(sum_lo);
         hi_out[r] = clamp32(sum_hi);
      end
      res.new_lo_x = lo_out[0]; res.new_lo_y = lo_out[1]; res.new_lo_z = lo_out[2];
      res.new_hi_x = hi_out[0]; res.new_hi_y = hi_out[1]; res.new_hi_z = hi_out[2];
      return res;
   endfunction

   function automatic logic [CoefW-1:0] rand_coef();
      case ($urandom_range(0, 3))
         0: return CoefW'($urandom);
         1: return CoefW'($urandom_range(0, 1 << 18) - (1 << 17));
         2: begin
            case ($urandom_range(0, 4))
               0: return COEF_MIN;
               1: return COEF_MAX;
               2: return '0;
               3: return COEF_ONE;
               default: return -COEF_ONE;
            endcase
         end
         default: return CoefW'($urandom_range(0, 1 << 16) - (1 << 15));
      endcase
   endfunction

   function automatic logic [CoordW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return COORD_MIN;
               1: return COORD_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return CoordW'($urandom_range(0, 1 << 23) - (1 << 22));
      endcase
   endfunction

   function automatic box_in_type rand_box();
      logic [CoordW-1:0] a [6];
      logic [CoordW-1:0] t;
      box_in_type box;
      foreach (a[i]) a[i] = rand_coord();
      // mostly well-formed boxes, some inverted
      if ($urandom_range(0, 3) != 0) begin
         for (int c = 0; c < 3; c++) begin
            if ($signed(a[c]) > $signed(a[c+3])) begin
               t = a[c]; a[c] = a[c+3]; a[c+3] = t;
            end
         end
      end
      box = '{a[0], a[1], a[2], a[3], a[4], a[5]};
      return box;
   endfunction

   function automatic logic [RowW-1:0] rand_row();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   // offset word with junk above the register width
   function automatic logic [RowW-1:0] rand_off();
      return {28'($urandom), rand_coord()};
   endfunction

   task automatic check_field(input string name, input logic [CoordW-1:0] want,
                              input logic [CoordW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : bounds_check
      box_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bounds_due.size() == 0) begin
            $error("result word with no expected bounds");
            mismatches++;
         end else begin
            want = bounds_due.pop_front();
            check_field("new_lo_x", want.new_lo_x, rsp_data.new_lo_x);
            check_field("new_lo_y", want.new_lo_y, rsp_data.new_lo_y);
            check_field("new_lo_z", want.new_lo_z, rsp_data.new_lo_z);
            check_field("new_hi_x", want.new_hi_x, rsp_data.new_hi_x);
            check_field("new_hi_y", want.new_hi_y, rsp_data.new_hi_y);
            check_field("new_hi_z", want.new_hi_z, rsp_data.new_hi_z);
         end
      end
   end

   always begin : rsp_pacing
      int n;
      @(posedge clock);
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         hold_cycles = 0;
         rsp_stall <= 1'b0;
      end else if (!steady && rsp_valid && !rsp_stall) begin
         n = $urandom_range(0, 5);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_box(input box_in_type box);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= box;
      do @(posedge clock); while (req_stall);
      bounds_due.push_back(map_box(box));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bounds_due.size() != 0) @(posedge clock);
      repeat (PipeDepth + 4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [RowW-1:0] value,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_XROW, CSR_YROW, CSR_ZROW: map_row[idx] = value;
         CSR_XOFF, CSR_YOFF, CSR_ZOFF: map_off[idx - CSR_XOFF] = value[CoordW-1:0];
         default: ;
      endcase
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic load_map(input logic [RowW-1:0] xr, yr, zr, xo, yo, zo);
      csr_write(CSR_XROW, xr, 1'b0);
      csr_write(CSR_YROW, yr, 1'b0);
      csr_write(CSR_ZROW, zr, 1'b0);
      csr_write(CSR_XOFF, xo, 1'b0);
      csr_write(CSR_YOFF, yo, 1'b0);
      csr_write(CSR_ZOFF, zo, 1'b1);
   endtask

   task automatic test_identity();
      offer_box('0);
      offer_box('{'0, '0, '0, COORD_ONE, COORD_ONE, COORD_ONE});
      offer_box('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX});
      offer_box('{COORD_ONE, 32'h0002_8000, '1, -COORD_ONE, '0, 32'hFFF0_0000});
      offer_box('{'1, '1, '1, '1, '1, '1});
      drain();
   endtask

   task automatic test_extreme_maps();
      load_map({3{COEF_MIN}}, {3{COEF_MIN}}, {3{COEF_MIN}},
               RowW'(COORD_MAX), RowW'(COORD_MAX), RowW'(COORD_MIN));
      offer_box('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX});
      offer_box('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN});
      offer_box('{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX});
      drain();
      load_map({3{COEF_MAX}}, {COEF_MAX, COEF_MIN, CoefW'(0)},
               {COEF_ONE, -COEF_ONE, COEF_MIN},
               RowW'(COORD_MIN), '0, RowW'(COORD_MAX));
      offer_box('{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX});
      offer_box('{COORD_MAX, '0, COORD_MIN, COORD_MIN, '1, COORD_MAX});
      offer_box('{-COORD_ONE, -COORD_ONE, -COORD_ONE, COORD_ONE, COORD_ONE, COORD_ONE});
      drain();
   endtask

   task automatic test_register_decode();
      // writes to unmapped indexes must leave the map alone
      csr_write(CSR_SPARE6, rand_row(), 1'b0);
      csr_write(CSR_SPARE7, {28'($urandom), 32'($urandom)}, 1'b0);
      csr_write(CSR_YROW, {COEF_ONE, 20'h08000, -COEF_ONE}, 1'b0);
      csr_write(CSR_XOFF, {28'hFFF_FFFF, COORD_ONE}, 1'b0);
      csr_write(CSR_ZOFF, {28'hAAA_AAAA, -COORD_ONE}, 1'b1);
      offer_box('{'0, '0, '0, COORD_ONE, COORD_ONE, COORD_ONE});
      offer_box('{32'hFFFF_0001, 32'h0000_FFFF, '1, 32'h0000_0001, 32'hFFFF_FFFE, '0});
      offer_box(rand_box());
      drain();
   endtask

   task automatic test_random_maps();
      for (int phase = 0; phase < 6; phase++) begin
         load_map(rand_row(), rand_row(), rand_row(), rand_off(), rand_off(), rand_off());
         steady = (phase == 3);
         repeat (110) offer_box(rand_box());
         drain();
         steady = 1'b0;
      end
   endtask

   task automatic test_backpressure();
      load_map(rand_row(), rand_row(), rand_row(), rand_off(), rand_off(), rand_off());
      steady      = 1'b1;
      hold_cycles = 60;
      repeat (40) offer_box(rand_box());
      drain();
      steady = 1'b0;
   endtask

   initial begin
      map_row = '{XROW_RESET, YROW_RESET, ZROW_RESET};
      map_off = '{default: '0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_identity();
      test_extreme_maps();
      test_register_decode();
      test_random_maps();
      test_backpressure();
      if (mismatches == 0)
         $display("aabb_affine_transform_tb passed");
      else
         $display("aabb_affine_transform_tb failed");
      $finish;
   end

   initial begin
      #400_000;
      $display("aabb_affine_transform_tb failed");
      $finish;
   end

endmodule
